/* rtl/url_path_query_tokenizer_assert.svh */
// Assertion macros shared by the tokenizer RTL.
`ifndef URL_PATH_QUERY_TOKENIZER_ASSERT_SVH
`define URL_PATH_QUERY_TOKENIZER_ASSERT_SVH

// Clocked property, disabled while reset is asserted.
`define UPQT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property checked during reset too.
`define UPQT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/upqt_pkg.sv */
// Types, constants and helper functions of the URL path and query tokenizer.
`default_nettype none

package upqt_pkg;

    localparam int MAX_TOK    = 3;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_QUEST   = 8'h3F;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_PERCENT = 8'h25;

    typedef enum logic [2:0] {
        K_PATH     = 3'd0,
        K_COMP_END = 3'd1,
        K_KEY      = 3'd2,
        K_VAL      = 3'd3,
        K_COMMIT   = 3'd4,
        K_DONE     = 3'd5,
        K_REJECT   = 3'd6
    } t_kind;

    typedef enum logic [7:0] {
        PH_START   = 8'b0000_0001,
        PH_COMP    = 8'b0000_0010,
        PH_SEP     = 8'b0000_0100,
        PH_KEY     = 8'b0000_1000,
        PH_KEY_ESC = 8'b0001_0000,
        PH_VAL     = 8'b0010_0000,
        PH_VAL_ESC = 8'b0100_0000,
        PH_REJECT  = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_tok;

    typedef struct packed {
        logic [1:0]             cnt;
        t_tok [MAX_TOK-1:0]     tok;
    } t_tok_set;

    // {valid, nibble}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'b0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic t_tok_set add_tok(input t_tok_set s, input t_kind k,
                                         input logic [7:0] d);
        t_tok_set r;
        r = s;
        if (s.cnt < 2'(MAX_TOK)) begin
            r.tok[s.cnt].kind = k;
            r.tok[s.cnt].data = d;
            r.tok[s.cnt].last = 1'b0;
            r.cnt             = s.cnt + 2'd1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/upqt_parser.sv */
// Input register, parse state and per-byte token generation.
`default_nettype none

`include "url_path_query_tokenizer_assert.svh"

module upqt_parser (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [7:0]        i_char,
    output upqt_pkg::t_tok_set     o_toks
);

    logic                r_in_valid;
    logic [7:0]          r_in_char;
    upqt_pkg::t_phase    r_phase, n_phase;
    logic                r_comp_open, n_comp_open;
    logic [1:0]          r_hex_cnt, n_hex_cnt;
    logic [7:0]          r_hex_acc, n_hex_acc;

    upqt_pkg::t_tok_set  set;
    upqt_pkg::t_kind     esc_kind;
    logic [4:0]          hv;
    logic                str_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_valid;
        end
        r_in_char <= i_char;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= upqt_pkg::PH_START;
            r_comp_open <= 1'b0;
            r_hex_cnt   <= 2'd0;
            r_hex_acc   <= 8'd0;
        end else begin
            r_phase     <= n_phase;
            r_comp_open <= n_comp_open;
            r_hex_cnt   <= n_hex_cnt;
            r_hex_acc   <= n_hex_acc;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_comp_open = r_comp_open;
        n_hex_cnt   = r_hex_cnt;
        n_hex_acc   = r_hex_acc;
        set         = '0;
        str_end     = 1'b0;
        hv          = upqt_pkg::hex_val(r_in_char);
        esc_kind    = (r_phase == upqt_pkg::PH_KEY_ESC) ? upqt_pkg::K_KEY : upqt_pkg::K_VAL;

        if (r_in_valid) begin
            unique case (r_phase)
                upqt_pkg::PH_COMP, upqt_pkg::PH_SEP: begin
                    if (r_in_char == upqt_pkg::CH_NUL || r_in_char == upqt_pkg::CH_SLASH ||
                        r_in_char == upqt_pkg::CH_QUEST) begin
                        if (r_comp_open) begin
                            set = upqt_pkg::add_tok(set, upqt_pkg::K_COMP_END, 8'd0);
                        end
                        n_comp_open = 1'b0;
                        if (r_in_char == upqt_pkg::CH_NUL) begin
                            set     = upqt_pkg::add_tok(set, upqt_pkg::K_DONE, 8'd0);
                            str_end = 1'b1;
                        end else if (r_in_char == upqt_pkg::CH_SLASH) begin
                            n_phase = upqt_pkg::PH_SEP;
                        end else begin
                            n_phase = upqt_pkg::PH_KEY;
                        end
                    end else begin
                        set         = upqt_pkg::add_tok(set, upqt_pkg::K_PATH, r_in_char);
                        n_comp_open = 1'b1;
                        n_phase     = upqt_pkg::PH_COMP;
                    end
                end
                upqt_pkg::PH_KEY: begin
                    if (r_in_char == upqt_pkg::CH_NUL) begin
                        set     = upqt_pkg::add_tok(set, upqt_pkg::K_DONE, 8'd0);
                        str_end = 1'b1;
                    end else if (r_in_char == upqt_pkg::CH_EQUAL) begin
                        n_phase = upqt_pkg::PH_VAL;
                    end else if (r_in_char == upqt_pkg::CH_PERCENT) begin
                        n_hex_cnt = 2'd0;
                        n_hex_acc = 8'd0;
                        n_phase   = upqt_pkg::PH_KEY_ESC;
                    end else begin
                        set = upqt_pkg::add_tok(set, upqt_pkg::K_KEY, r_in_char);
                    end
                end
                upqt_pkg::PH_VAL: begin
                    if (r_in_char == upqt_pkg::CH_NUL) begin
                        set     = upqt_pkg::add_tok(set, upqt_pkg::K_COMMIT, 8'd0);
                        set     = upqt_pkg::add_tok(set, upqt_pkg::K_DONE, 8'd0);
                        str_end = 1'b1;
                    end else if (r_in_char == upqt_pkg::CH_AMP) begin
                        set     = upqt_pkg::add_tok(set, upqt_pkg::K_COMMIT, 8'd0);
                        n_phase = upqt_pkg::PH_KEY;
                    end else if (r_in_char == upqt_pkg::CH_PERCENT) begin
                        n_hex_cnt = 2'd0;
                        n_hex_acc = 8'd0;
                        n_phase   = upqt_pkg::PH_VAL_ESC;
                    end else begin
                        set = upqt_pkg::add_tok(set, upqt_pkg::K_VAL, r_in_char);
                    end
                end
                upqt_pkg::PH_KEY_ESC, upqt_pkg::PH_VAL_ESC: begin
                    if (r_phase == upqt_pkg::PH_KEY_ESC && r_in_char == upqt_pkg::CH_NUL) begin
                        // incomplete key: drop pending escape byte
                        set     = upqt_pkg::add_tok(set, upqt_pkg::K_DONE, 8'd0);
                        str_end = 1'b1;
                    end else if (hv[4]) begin
                        if (r_hex_cnt < 2'd2) begin
                            n_hex_acc = {r_hex_acc[3:0], hv[3:0]};
                            n_hex_cnt = r_hex_cnt + 2'd1;
                        end else begin
                            if (r_hex_cnt == 2'd2) begin
                                set       = upqt_pkg::add_tok(set, esc_kind, r_hex_acc);
                                n_hex_cnt = 2'd3;
                            end
                            set = upqt_pkg::add_tok(set, esc_kind, r_in_char);
                        end
                    end else begin
                        // close the escape, emit decoded byte unless already out
                        if (r_hex_cnt != 2'd3) begin
                            set = upqt_pkg::add_tok(set, esc_kind, r_hex_acc);
                        end
                        n_hex_cnt = 2'd0;
                        n_hex_acc = 8'd0;
                        if (r_phase == upqt_pkg::PH_KEY_ESC) begin
                            if (r_in_char == upqt_pkg::CH_EQUAL) begin
                                n_phase = upqt_pkg::PH_VAL;
                            end else if (r_in_char != upqt_pkg::CH_PERCENT) begin
                                set     = upqt_pkg::add_tok(set, upqt_pkg::K_KEY, r_in_char);
                                n_phase = upqt_pkg::PH_KEY;
                            end
                        end else begin
                            if (r_in_char == upqt_pkg::CH_NUL) begin
                                set     = upqt_pkg::add_tok(set, upqt_pkg::K_COMMIT, 8'd0);
                                set     = upqt_pkg::add_tok(set, upqt_pkg::K_DONE, 8'd0);
                                str_end = 1'b1;
                            end else if (r_in_char == upqt_pkg::CH_AMP) begin
                                set     = upqt_pkg::add_tok(set, upqt_pkg::K_COMMIT, 8'd0);
                                n_phase = upqt_pkg::PH_KEY;
                            end else if (r_in_char != upqt_pkg::CH_PERCENT) begin
                                set     = upqt_pkg::add_tok(set, upqt_pkg::K_VAL, r_in_char);
                                n_phase = upqt_pkg::PH_VAL;
                            end
                        end
                    end
                end
                upqt_pkg::PH_REJECT: begin
                    if (r_in_char == upqt_pkg::CH_NUL) begin
                        set     = upqt_pkg::add_tok(set, upqt_pkg::K_REJECT, 8'd0);
                        str_end = 1'b1;
                    end
                end
                default: begin
                    if (r_in_char == upqt_pkg::CH_SLASH) begin
                        n_phase     = upqt_pkg::PH_COMP;
                        n_comp_open = 1'b0;
                    end else if (r_in_char == upqt_pkg::CH_NUL) begin
                        set     = upqt_pkg::add_tok(set, upqt_pkg::K_REJECT, 8'd0);
                        str_end = 1'b1;
                    end else begin
                        n_phase = upqt_pkg::PH_REJECT;
                    end
                end
            endcase

            // end of string: back to reset values
            if (str_end) begin
                n_phase     = upqt_pkg::PH_START;
                n_comp_open = 1'b0;
                n_hex_cnt   = 2'd0;
                n_hex_acc   = 8'd0;
            end

            if (set.cnt != 2'd0) begin
                set.tok[set.cnt - 2'd1].last = 1'b1;
            end
        end
    end

    assign o_toks = set;

    `UPQT_ASSERT(a_tok_needs_beat, i_clk, i_rst_n, ((set.cnt != 2'd0) |-> r_in_valid), "tokens without a registered beat")
    `UPQT_ASSERT(a_end_resets, i_clk, i_rst_n, ((r_in_valid && str_end) |=> (r_phase == upqt_pkg::PH_START && r_hex_cnt == 2'd0 && !r_comp_open)), "state not cleared after end of string")

endmodule

`default_nettype wire

/* rtl/upqt_token_fifo.sv */
// Token buffer: takes up to three tokens a cycle, hands out one per beat.
`default_nettype none

`include "url_path_query_tokenizer_assert.svh"

module upqt_token_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  upqt_pkg::t_tok_set     i_toks,
    output logic                   o_space_ok,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output upqt_pkg::t_tok         o_tok
);

    upqt_pkg::t_tok                   r_mem [upqt_pkg::FIFO_DEPTH];
    logic [upqt_pkg::FIFO_AW-1:0]     r_wr_ptr, r_rd_ptr;
    logic [upqt_pkg::FIFO_AW:0]       r_count, n_count;
    logic                             pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && i_ready;
    assign o_tok   = r_mem[r_rd_ptr];
    // room for the beat in the parser register plus one more beat
    assign o_space_ok = (r_count <= (upqt_pkg::FIFO_AW+1)'(upqt_pkg::FIFO_DEPTH - 2*upqt_pkg::MAX_TOK));

    assign n_count = r_count + (upqt_pkg::FIFO_AW+1)'(i_toks.cnt)
                   - (upqt_pkg::FIFO_AW+1)'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + upqt_pkg::FIFO_AW'(i_toks.cnt);
            r_rd_ptr <= r_rd_ptr + upqt_pkg::FIFO_AW'(pop);
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < upqt_pkg::MAX_TOK; i++) begin
            if (2'(i) < i_toks.cnt) begin
                r_mem[r_wr_ptr + upqt_pkg::FIFO_AW'(i)] <= i_toks.tok[i];
            end
        end
    end

    `UPQT_ASSERT(a_no_overflow, i_clk, i_rst_n, (({1'b0, r_count} + (upqt_pkg::FIFO_AW+2)'(i_toks.cnt)) <= (upqt_pkg::FIFO_AW+2)'(upqt_pkg::FIFO_DEPTH)), "token buffer overflow")
    `UPQT_ASSERT(a_push_shows, i_clk, i_rst_n, ((r_count == '0 && i_toks.cnt != 2'd0) |=> o_valid), "pushed token not presented")

endmodule

`default_nettype wire

/* rtl/url_path_query_tokenizer.sv */
// Path: a byte accepted at an edge is held in the parser input register and parsed from there;
// its tokens are written into the token buffer and are shown on the master side from there.
// Throughput: one byte per cycle while the token buffer keeps six free slots; a byte
// that yields k tokens takes k output beats, so the output side sets the long-run rate.
// Reset: synchronous, active low; clears the parse state and empties the token buffer.
`default_nettype none

module url_path_query_tokenizer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] data_byte
    output logic [2:0]       m_axis_tuser,   // [2:0] kind
    output logic             m_axis_tlast
);

    upqt_pkg::t_tok_set toks;
    upqt_pkg::t_tok     head;
    logic               space_ok;

    assign s_axis_tready = space_ok;

    upqt_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid && space_ok),
        .i_char  (s_axis_tdata),
        .o_toks  (toks)
    );

    upqt_token_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_toks     (toks),
        .o_space_ok (space_ok),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_tok      (head)
    );

    assign m_axis_tdata = head.data;
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

endmodule

`default_nettype wire
